/* design/hkc_pkg.sv */
// ----------------------------------------------------------------------------
// hkc_pkg: shared definitions of the hot key cache
// Table geometry, scoring constants, transaction payload types, codes and
// the control types that pass between the cache modules.
// ----------------------------------------------------------------------------
package hkc_pkg;

    localparam int DEPTH           = 256;
    localparam int IDX_W           = $clog2(DEPTH);
    localparam int OCC_W           = $clog2(DEPTH + 1);
    localparam int PASS_LEN        = DEPTH + 2;
    localparam int CNT_W           = $clog2(PASS_LEN);
    localparam int FREQ_WEIGHT     = 1000000;
    localparam int FREQ_W          = $clog2(FREQ_WEIGHT + 1);
    localparam int BYTES_PER_ENTRY = 96;
    localparam int MIB_SHIFT       = 20;
    localparam int N_STATS         = 5;

    localparam logic [2:0] KIND_LOOKUP = 3'd0;
    localparam logic [2:0] KIND_PUT    = 3'd1;
    localparam logic [2:0] KIND_INVAL  = 3'd2;
    localparam logic [2:0] KIND_EVICT  = 3'd3;
    localparam logic [2:0] KIND_CLEAR  = 3'd4;
    localparam logic [2:0] KIND_STAT   = 3'd5;

    localparam logic [2:0] ST_LOOKUPS = 3'd0;
    localparam logic [2:0] ST_HITS    = 3'd1;
    localparam logic [2:0] ST_MISSES  = 3'd2;
    localparam logic [2:0] ST_INSERTS = 3'd3;
    localparam logic [2:0] ST_EVICTS  = 3'd4;

    localparam logic REG_ENTRY_CAP = 1'b0;
    localparam logic REG_TARGET_MB = 1'b1;

    typedef enum logic [1:0] {S_IDLE, S_PASS, S_DONE} state_t;

    typedef enum logic [2:0] {OP_LOOKUP, OP_INVAL, OP_MIN, OP_FIND, OP_WRITE} op_t;

    typedef struct packed {
        logic [63:0] key;
        logic [63:0] offset;
        logic [63:0] row;
        logic [31:0] hits;
        logic [63:0] stamp;
    } slot_t;

    typedef struct packed {
        logic             vld;
        logic [IDX_W-1:0] idx;
        logic [31:0]      hits;
        logic [63:0]      stamp;
    } score_smp_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [63:0] key;
        logic [63:0] now;
        logic [63:0] offset_in;
        logic [63:0] row_in;
        logic [2:0]  stat_select;
    } in_item_t;

    typedef struct packed {
        logic        found;
        logic [63:0] entry_offset;
        logic [63:0] entry_row;
        logic [31:0] entry_count;
        logic [63:0] entry_time;
        logic [8:0]  evictions_done;
        logic [8:0]  occupancy;
        logic [31:0] stat_value;
    } out_item_t;

endpackage

/* design/hkc_cell.sv */
// ----------------------------------------------------------------------------
// hkc_cell: one slot of the rotating table
// Holds a valid bit and an entry and hands both to its neighbor on a shift.
// ----------------------------------------------------------------------------
module hkc_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            shift,
    input  logic            clear_all,
    input  logic            valid_in,
    input  hkc_pkg::slot_t  data_in,
    output logic            valid_out,
    output hkc_pkg::slot_t  data_out
);

    logic           valid_reg;
    hkc_pkg::slot_t data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (clear_all)
        begin
            valid_reg <= 1'b0;
        end
        else if (shift)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            data_reg <= data_in;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

/* design/hkc_victim.sv */
// ----------------------------------------------------------------------------
// hkc_victim: minimum score tracker
// Scores each passing slot as time plus weighted hit count in two stages and
// keeps the lowest score; the earliest slot wins a tie.
// ----------------------------------------------------------------------------
module hkc_victim (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  hkc_pkg::score_smp_t       smp,
    output logic                      best_vld,
    output logic [hkc_pkg::IDX_W-1:0] best_idx
);

    localparam logic [hkc_pkg::FREQ_W-1:0] WEIGHT = hkc_pkg::FREQ_W'(hkc_pkg::FREQ_WEIGHT);

    logic                            s1_vld_reg;
    logic [hkc_pkg::IDX_W-1:0]       s1_idx_reg;
    logic [31+hkc_pkg::FREQ_W:0]     s1_prod_reg;
    logic [63:0]                     s1_stamp_reg;
    logic                            best_vld_reg;
    logic [hkc_pkg::IDX_W-1:0]       best_idx_reg;
    logic [63:0]                     best_score_reg;
    logic [63:0]                     score;
    logic                            better;

    assign score  = s1_stamp_reg + 64'(s1_prod_reg);
    assign better = s1_vld_reg && (!best_vld_reg || (score < best_score_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg   <= 1'b0;
            best_vld_reg <= 1'b0;
        end
        else if (start)
        begin
            s1_vld_reg   <= 1'b0;
            best_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= smp.vld;
            if (better)
            begin
                best_vld_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_idx_reg   <= smp.idx;
        s1_prod_reg  <= smp.hits * WEIGHT;
        s1_stamp_reg <= smp.stamp;
        if (better)
        begin
            best_idx_reg   <= s1_idx_reg;
            best_score_reg <= score;
        end
    end

    assign best_vld = best_vld_reg;
    assign best_idx = best_idx_reg;

endmodule

/* design/hot_key_cache_weighted_evict.sv */
// ----------------------------------------------------------------------------
// hot_key_cache_weighted_evict: fully associative hot key cache
// Key table with weighted recency and frequency eviction, built as a ring of
// slot cells that rotates past one processing head.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on the in channel (in_valid, in_stall, in_data) and every
// request transaction yields exactly one response transaction on the out
// channel (out_valid, out_stall, out_data). The table is a ring of 256 cells
// that shifts by one slot per cycle during a pass; the head of the ring is
// where a slot is compared, scored and rewritten. One pass over the table is
// one shift per slot, followed by a drain of the score pipeline.
// Latency: clear, read statistic and unknown kinds run no pass and respond
// directly; lookup and invalidate take one pass; evict takes one pass, or two
// when an entry is removed; a put takes (E + 3) passes, E being the number of
// entries it evicts first. The pass length is set by the ring rotation.
// One request is processed at a time; in_stall is high while a request is in
// progress. A response waits in an output register while out_stall is high,
// and the next request may be taken meanwhile.
// After reset the table is empty, the statistics are zero, the entry limit
// is 256 and the memory budget is 64 MiB. The APB port is to write the limits
// only while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module hot_key_cache_weighted_evict (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  hkc_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output hkc_pkg::out_item_t  out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int DEPTH = hkc_pkg::DEPTH;
    localparam int IDX_W = hkc_pkg::IDX_W;
    localparam int OCC_W = hkc_pkg::OCC_W;
    localparam int CNT_W = hkc_pkg::CNT_W;
    localparam int LIM_W = 16 + hkc_pkg::MIB_SHIFT + 2;
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(hkc_pkg::PASS_LEN - 1);

    // Configuration registers.
    logic [8:0]  entry_cap_reg;
    logic [15:0] target_mb_reg;
    logic        cfg_wr;

    // Control state.
    hkc_pkg::state_t state_reg, state_next;
    hkc_pkg::op_t    op_reg, op_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [OCC_W-1:0] used_reg, used_next;
    logic [8:0]       evicted_reg, evicted_next;
    logic             hit_reg, hit_next;
    logic             kill_pend_reg, kill_pend_next;
    logic [IDX_W-1:0] kill_idx_reg, kill_idx_next;
    logic             match_found_reg, match_found_next;
    logic [IDX_W-1:0] match_idx_reg, match_idx_next;
    logic             free_found_reg, free_found_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;
    logic [31:0]      stat_reg [hkc_pkg::N_STATS];
    logic [31:0]      stat_next [hkc_pkg::N_STATS];
    logic             out_valid_reg, out_valid_next;

    // Request payload and result accumulators.
    hkc_pkg::in_item_t  item_reg, item_next;
    hkc_pkg::out_item_t res_reg, res_next;
    hkc_pkg::out_item_t out_reg, out_next;

    // Ring signals.
    logic             cell_valid [DEPTH];
    hkc_pkg::slot_t   cell_data [DEPTH];
    logic             rot;
    logic             clear_all;
    logic             mod_v;
    hkc_pkg::slot_t   mod;
    logic             start;
    hkc_pkg::score_smp_t smp;
    logic             best_vld;
    logic [IDX_W-1:0] best_idx;
    logic             out_free;
    logic             key_hit;
    logic [IDX_W-1:0] head_idx;
    logic [IDX_W-1:0] tgt_idx;

    // ------------------------------------------------------------------
    // APB register port: writes complete in the access phase.
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == hkc_pkg::REG_TARGET_MB) ? {16'b0, target_mb_reg}
                                                         : {23'b0, entry_cap_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_cap_reg <= 9'd256;
            target_mb_reg <= 16'd64;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == hkc_pkg::REG_TARGET_MB)
            begin
                target_mb_reg <= pwdata[15:0];
            end
            else if (paddr[2] == hkc_pkg::REG_ENTRY_CAP)
            begin
                entry_cap_reg <= pwdata[8:0];
            end
        end
    end

    // A put evicts while the table is at its entry limit, full, or at its
    // memory budget.
    function automatic logic over_limit(input logic [OCC_W-1:0] used,
                                        input logic [8:0] max_e,
                                        input logic [15:0] mb);
        logic [LIM_W-1:0] bytes_used;
        logic [LIM_W-1:0] budget;
        bytes_used = LIM_W'(used) * LIM_W'(hkc_pkg::BYTES_PER_ENTRY);
        budget     = LIM_W'(mb) << hkc_pkg::MIB_SHIFT;
        return (OCC_W'(max_e) <= used) || (used >= OCC_W'(DEPTH)) || (bytes_used >= budget);
    endfunction

    // ------------------------------------------------------------------
    // Ring of slot cells. Cell 0 is the head; its processed entry re-enters
    // at the far end so that a full pass restores the slot order.
    // ------------------------------------------------------------------
    for (genvar gi = 0; gi < DEPTH; gi++)
    begin : g_ring
        if (gi == DEPTH - 1)
        begin : g_tail
            hkc_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .shift     (rot),
                .clear_all (clear_all),
                .valid_in  (mod_v),
                .data_in   (mod),
                .valid_out (cell_valid[gi]),
                .data_out  (cell_data[gi])
            );
        end
        else
        begin : g_body
            hkc_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .shift     (rot),
                .clear_all (clear_all),
                .valid_in  (cell_valid[gi+1]),
                .data_in   (cell_data[gi+1]),
                .valid_out (cell_valid[gi]),
                .data_out  (cell_data[gi])
            );
        end
    end

    hkc_victim u_victim (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .smp      (smp),
        .best_vld (best_vld),
        .best_idx (best_idx)
    );

    assign out_free = !out_valid_reg || !out_stall;
    assign head_idx = cnt_reg[IDX_W-1:0];
    assign key_hit  = cell_valid[0] && (cell_data[0].key == item_reg.key);
    assign tgt_idx  = match_found_reg ? match_idx_reg : free_idx_reg;

    // ------------------------------------------------------------------
    // Head processing and sequencing.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        cnt_next         = cnt_reg;
        used_next        = used_reg;
        evicted_next     = evicted_reg;
        hit_next         = hit_reg;
        kill_pend_next   = kill_pend_reg;
        kill_idx_next    = kill_idx_reg;
        match_found_next = match_found_reg;
        match_idx_next   = match_idx_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        stat_next        = stat_reg;
        out_valid_next   = out_valid_reg;
        item_next        = item_reg;
        res_next         = res_reg;
        out_next         = out_reg;
        rot              = 1'b0;
        clear_all        = 1'b0;
        start            = 1'b0;
        mod_v            = cell_valid[0];
        mod              = cell_data[0];
        smp.vld          = 1'b0;
        smp.idx          = head_idx;
        smp.hits         = cell_data[0].hits;
        smp.stamp        = cell_data[0].stamp;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            hkc_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    item_next        = in_data;
                    res_next         = '0;
                    cnt_next         = '0;
                    evicted_next     = '0;
                    hit_next         = 1'b0;
                    kill_pend_next   = 1'b0;
                    match_found_next = 1'b0;
                    free_found_next  = 1'b0;
                    state_next       = hkc_pkg::S_DONE;
                    case (in_data.kind)
                        hkc_pkg::KIND_LOOKUP:
                        begin
                            stat_next[hkc_pkg::ST_LOOKUPS] = stat_reg[hkc_pkg::ST_LOOKUPS] + 32'd1;
                            op_next    = hkc_pkg::OP_LOOKUP;
                            state_next = hkc_pkg::S_PASS;
                            start      = 1'b1;
                        end
                        hkc_pkg::KIND_PUT, hkc_pkg::KIND_EVICT:
                        begin
                            op_next    = hkc_pkg::OP_MIN;
                            state_next = hkc_pkg::S_PASS;
                            start      = 1'b1;
                        end
                        hkc_pkg::KIND_INVAL:
                        begin
                            op_next    = hkc_pkg::OP_INVAL;
                            state_next = hkc_pkg::S_PASS;
                            start      = 1'b1;
                        end
                        hkc_pkg::KIND_CLEAR:
                        begin
                            clear_all = 1'b1;
                            used_next = '0;
                        end
                        hkc_pkg::KIND_STAT:
                        begin
                            if (in_data.stat_select < 3'(hkc_pkg::N_STATS))
                            begin
                                res_next.stat_value = stat_reg[in_data.stat_select];
                            end
                        end
                        default:
                        begin
                            res_next = '0;
                        end
                    endcase
                end
            end

            hkc_pkg::S_PASS:
            begin
                rot = (cnt_reg < CNT_W'(DEPTH));
                if (rot)
                begin
                    case (op_reg)
                        hkc_pkg::OP_LOOKUP:
                        begin
                            if (key_hit && !hit_reg)
                            begin
                                hit_next              = 1'b1;
                                res_next.entry_offset = cell_data[0].offset;
                                res_next.entry_row    = cell_data[0].row;
                                res_next.entry_count  = cell_data[0].hits;
                                res_next.entry_time   = cell_data[0].stamp;
                                mod.hits              = cell_data[0].hits + 32'd1;
                                mod.stamp             = item_reg.now;
                            end
                        end
                        hkc_pkg::OP_INVAL:
                        begin
                            if (key_hit && !hit_reg)
                            begin
                                hit_next  = 1'b1;
                                mod_v     = 1'b0;
                                used_next = used_reg - OCC_W'(1);
                            end
                        end
                        hkc_pkg::OP_MIN:
                        begin
                            if (kill_pend_reg && (head_idx == kill_idx_reg))
                            begin
                                mod_v        = 1'b0;
                                used_next    = used_reg - OCC_W'(1);
                                evicted_next = evicted_reg + 9'd1;
                                stat_next[hkc_pkg::ST_EVICTS] =
                                    stat_reg[hkc_pkg::ST_EVICTS] + 32'd1;
                            end
                            smp.vld = mod_v;
                        end
                        hkc_pkg::OP_FIND:
                        begin
                            if (key_hit && !match_found_reg)
                            begin
                                match_found_next = 1'b1;
                                match_idx_next   = head_idx;
                            end
                            if (!cell_valid[0] && !free_found_reg)
                            begin
                                free_found_next = 1'b1;
                                free_idx_next   = head_idx;
                            end
                        end
                        hkc_pkg::OP_WRITE:
                        begin
                            if (head_idx == tgt_idx)
                            begin
                                if (match_found_reg)
                                begin
                                    mod.offset = item_reg.offset_in;
                                    mod.row    = item_reg.row_in;
                                    mod.hits   = cell_data[0].hits + 32'd1;
                                    mod.stamp  = item_reg.now;
                                end
                                else if (free_found_reg)
                                begin
                                    mod_v      = 1'b1;
                                    mod.key    = item_reg.key;
                                    mod.offset = item_reg.offset_in;
                                    mod.row    = item_reg.row_in;
                                    mod.hits   = 32'd1;
                                    mod.stamp  = item_reg.now;
                                    used_next  = used_reg + OCC_W'(1);
                                    stat_next[hkc_pkg::ST_INSERTS] =
                                        stat_reg[hkc_pkg::ST_INSERTS] + 32'd1;
                                end
                            end
                        end
                        default:
                        begin
                            mod_v = cell_valid[0];
                        end
                    endcase
                end

                if (cnt_reg == LAST_CNT)
                begin
                    cnt_next = '0;
                    case (op_reg)
                        hkc_pkg::OP_LOOKUP:
                        begin
                            if (hit_reg)
                            begin
                                stat_next[hkc_pkg::ST_HITS] = stat_reg[hkc_pkg::ST_HITS] + 32'd1;
                            end
                            else
                            begin
                                stat_next[hkc_pkg::ST_MISSES] =
                                    stat_reg[hkc_pkg::ST_MISSES] + 32'd1;
                            end
                            res_next.found = hit_reg;
                            state_next     = hkc_pkg::S_DONE;
                        end
                        hkc_pkg::OP_MIN:
                        begin
                            if (item_reg.kind == hkc_pkg::KIND_EVICT)
                            begin
                                if (kill_pend_reg)
                                begin
                                    kill_pend_next = 1'b0;
                                    res_next.found = 1'b1;
                                    state_next     = hkc_pkg::S_DONE;
                                end
                                else if (best_vld)
                                begin
                                    kill_pend_next = 1'b1;
                                    kill_idx_next  = best_idx;
                                    start          = 1'b1;
                                end
                                else
                                begin
                                    state_next = hkc_pkg::S_DONE;
                                end
                            end
                            else
                            begin
                                start          = 1'b1;
                                kill_pend_next = 1'b0;
                                if ((used_reg != '0) && best_vld &&
                                    over_limit(used_reg, entry_cap_reg, target_mb_reg))
                                begin
                                    kill_pend_next = 1'b1;
                                    kill_idx_next  = best_idx;
                                end
                                else
                                begin
                                    op_next = hkc_pkg::OP_FIND;
                                end
                            end
                        end
                        hkc_pkg::OP_FIND:
                        begin
                            op_next = hkc_pkg::OP_WRITE;
                            start   = 1'b1;
                        end
                        default:
                        begin
                            state_next = hkc_pkg::S_DONE;
                        end
                    endcase
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end

            hkc_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    out_next                = res_reg;
                    out_next.evictions_done = evicted_reg;
                    out_next.occupancy      = 9'(used_reg);
                    out_valid_next          = 1'b1;
                    state_next              = hkc_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = hkc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= hkc_pkg::S_IDLE;
            op_reg          <= hkc_pkg::OP_LOOKUP;
            cnt_reg         <= '0;
            used_reg        <= '0;
            evicted_reg     <= '0;
            hit_reg         <= 1'b0;
            kill_pend_reg   <= 1'b0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
            for (int i = 0; i < hkc_pkg::N_STATS; i++)
            begin
                stat_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg       <= state_next;
            op_reg          <= op_next;
            cnt_reg         <= cnt_next;
            used_reg        <= used_next;
            evicted_reg     <= evicted_next;
            hit_reg         <= hit_next;
            kill_pend_reg   <= kill_pend_next;
            match_found_reg <= match_found_next;
            free_found_reg  <= free_found_next;
            out_valid_reg   <= out_valid_next;
            stat_reg        <= stat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        res_reg       <= res_next;
        out_reg       <= out_next;
        kill_idx_reg  <= kill_idx_next;
        match_idx_reg <= match_idx_next;
        free_idx_reg  <= free_idx_next;
    end

    assign in_stall  = (state_reg != hkc_pkg::S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= OCC_W'(DEPTH))
        else $error("occupancy above table depth");

    a_kill_op: assert property (@(posedge clk) disable iff (!rst_n)
        kill_pend_reg |-> (op_reg == hkc_pkg::OP_MIN))
        else $error("pending eviction outside a victim pass");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hkc_pkg::S_PASS) |-> (cnt_reg <= LAST_CNT))
        else $error("pass counter out of range");

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg != hkc_pkg::S_IDLE))
        else $error("accepted transaction produced no work");

endmodule
